[hw/rtl/cptq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptq_pkg: shared constants
// Action codes, status codes and widths of the coalescing priority task queue.
// ----------------------------------------------------------------------------
package cptq_pkg;

   localparam int NUM_TASKS     = 64;
   localparam int PRIORITY_BITS = 8;
   localparam int SLOT_BITS     = $clog2(NUM_TASKS);
   localparam int LEN_BITS      = $clog2(NUM_TASKS + 1);
   localparam int COUNT_BITS    = 16;

   localparam logic [2:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [2:0] ACT_TAKE     = 3'd1;
   localparam logic [2:0] ACT_FINISH   = 3'd2;
   localparam logic [2:0] ACT_CANCEL   = 3'd3;
   localparam logic [2:0] ACT_BLOCK    = 3'd4;
   localparam logic [2:0] ACT_UNBLOCK  = 3'd5;
   localparam logic [2:0] ACT_SHUTDOWN = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INACTIVE = 2'd1;
   localparam logic [1:0] ST_BUSY     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [0:0] REG_HAS_NOTIFIER = 1'd0;

endpackage

[hw/rtl/coalescing_priority_task_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_priority_task_queue: priority work queue with coalescing
// Linked-list priority queue of task slots kept in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on req_* (action, task_id, priority_req) is accepted with
//   req_valid/req_ready and answered by exactly one result on rsp_*, in order.
//   The APB-style psel/penable port holds has_notifier at address 0; write it
//   only while no request is in flight.
// Timing: one request is worked on at a time; req_ready is high only in IDLE.
//   An accepted request passes READ and DECIDE, then walks the list one entry
//   at a time in INS or CAN for a sorted insert or a mid-list cancel, writes a
//   second node in WRNEW or CAN2 (append, mid-list insert, mid-list cancel of a
//   slot other than the tail) and waits in DONE. The next request is accepted
//   the cycle after the result is loaded into the output register.
// Stall: hold the result in the output register while rsp_ready is low; the
//   next request is still accepted and its result waits in DONE until the
//   output register frees.
// Reset: the list is empty, the queue active and the notifier attached.
//   Pending counts read as zero through per-slot valid bits cleared at reset.
// ----------------------------------------------------------------------------
module coalescing_priority_task_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_action,
   input  logic [cptq_pkg::SLOT_BITS-1:0]      req_task_id,
   input  logic [cptq_pkg::PRIORITY_BITS-1:0]  req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [cptq_pkg::SLOT_BITS-1:0]      rsp_task_out,
   output logic                                rsp_task_valid,
   output logic [cptq_pkg::COUNT_BITS-1:0]     rsp_pending_count,
   output logic                                rsp_notify,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int SB = cptq_pkg::SLOT_BITS;
   localparam int PB = cptq_pkg::PRIORITY_BITS;
   localparam int LB = cptq_pkg::LEN_BITS;
   localparam int CB = cptq_pkg::COUNT_BITS;
   localparam int N  = cptq_pkg::NUM_TASKS;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DECIDE, S_INS, S_WRNEW, S_CAN, S_CAN2, S_DONE
   } state_type;

   typedef struct packed {
      logic [SB-1:0] link;
      logic [PB-1:0] prio;
   } node_type;

   // memories: list node (next link and priority) and pending count per slot
   node_type      node_mem [N];
   logic [CB-1:0] count_mem [N];
   logic [N-1:0]  count_ok_ff;

   logic          node_we;
   logic [SB-1:0] node_wa, node_ra;
   node_type      node_wd, node_rd_ff;
   logic          cnt_we;
   logic [SB-1:0] cnt_wa, cnt_ra;
   logic [CB-1:0] cnt_wd, cnt_raw_ff, cnt_rd;
   logic          cnt_okr_ff;

   // control state
   state_type     st_ff, st_in;
   logic [2:0]    act_ff, act_in;
   logic [SB-1:0] tid_ff, tid_in;
   logic [PB-1:0] pri_ff, pri_in;
   logic [SB-1:0] head_ff, head_in, tail_ff, tail_in, run_ff, run_in;
   logic [LB-1:0] len_ff, len_in;
   logic          runv_ff, runv_in, blk_ff, blk_in, def_ff, def_in;
   logic          on_ff, on_in, notif_ff, notif_in;
   logic [SB-1:0] cur_ff, cur_in, prev_ff, prev_in, new_link_ff, new_link_in;
   logic [PB-1:0] prev_pri_ff, prev_pri_in;
   logic          hprev_ff, hprev_in;
   // result being built
   logic [1:0]    r_st_ff, r_st_in;
   logic [SB-1:0] r_to_ff, r_to_in;
   logic          r_tv_ff, r_tv_in, r_nt_ff, r_nt_in;
   logic [CB-1:0] r_cnt_ff, r_cnt_in;
   // output register
   logic          o_v_ff, o_v_in;
   logic [1:0]    o_st_ff, o_st_in;
   logic [SB-1:0] o_to_ff, o_to_in;
   logic          o_tv_ff, o_tv_in, o_nt_ff, o_nt_in;
   logic [CB-1:0] o_cnt_ff, o_cnt_in;

   logic          csr_wr;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      cnt_raw_ff <= count_mem[cnt_ra];
   end

   // a slot never written reads as a zero count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ok_ff <= '0;
         cnt_okr_ff  <= 1'b0;
      end else begin
         if (cnt_we) begin
            count_ok_ff[cnt_wa] <= 1'b1;
         end
         cnt_okr_ff <= count_ok_ff[cnt_ra];
      end
   end
   assign cnt_rd = cnt_okr_ff ? cnt_raw_ff : '0;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == cptq_pkg::REG_HAS_NOTIFIER) ? {31'd0, notif_ff} : 32'd0;

   assign req_ready         = (st_ff == S_IDLE);
   assign rsp_valid         = o_v_ff;
   assign rsp_status        = o_st_ff;
   assign rsp_task_out      = o_to_ff;
   assign rsp_task_valid    = o_tv_ff;
   assign rsp_pending_count = o_cnt_ff;
   assign rsp_notify        = o_nt_ff;

   assign out_free = !o_v_ff || rsp_ready;

   always_comb begin
      st_in = st_ff; act_in = act_ff; tid_in = tid_ff; pri_in = pri_ff;
      head_in = head_ff; tail_in = tail_ff; run_in = run_ff; len_in = len_ff;
      runv_in = runv_ff; blk_in = blk_ff; def_in = def_ff; on_in = on_ff;
      cur_in = cur_ff; prev_in = prev_ff; prev_pri_in = prev_pri_ff;
      hprev_in = hprev_ff; new_link_in = new_link_ff;
      r_st_in = r_st_ff; r_to_in = r_to_ff; r_tv_in = r_tv_ff; r_nt_in = r_nt_ff;
      r_cnt_in = r_cnt_ff;
      o_v_in = o_v_ff && !rsp_ready;
      o_st_in = o_st_ff; o_to_in = o_to_ff; o_tv_in = o_tv_ff; o_nt_in = o_nt_ff;
      o_cnt_in = o_cnt_ff;
      notif_in = notif_ff;
      node_we = 1'b0; node_wa = tid_ff; node_ra = head_ff;
      node_wd.link = new_link_ff; node_wd.prio = pri_ff;
      cnt_we = 1'b0; cnt_wa = tid_ff; cnt_wd = '0; cnt_ra = tid_ff;
      if (csr_wr && paddr[2] == cptq_pkg::REG_HAS_NOTIFIER) begin
         notif_in = pwdata[0];
      end
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; tid_in = req_task_id; pri_in = req_priority_req;
               r_st_in = cptq_pkg::ST_OK; r_to_in = '0; r_tv_in = 1'b0;
               r_nt_in = 1'b0; r_cnt_in = '0;
               st_in = S_READ;
            end
         end
         S_READ: begin
            // fetch the count of the addressed slot and the node the action needs
            if (act_ff == cptq_pkg::ACT_TAKE) begin
               cnt_ra = head_ff;
            end
            if (act_ff == cptq_pkg::ACT_ENQUEUE) begin
               node_ra = tail_ff;
            end
            st_in = S_DECIDE;
         end
         S_DECIDE: begin
            st_in = S_DONE;
            case (act_ff)
               cptq_pkg::ACT_ENQUEUE: begin
                  if (!on_ff) begin
                     r_st_in = cptq_pkg::ST_INACTIVE;
                  end else if (cnt_rd != '0) begin
                     // coalesce: bump the count, keep the queued priority
                     cnt_we = (cnt_rd != cptq_pkg::COUNT_MAX);
                     cnt_wd = cnt_rd + 1'b1;
                  end else begin
                     cnt_we = 1'b1; cnt_wd = CB'(1);
                     len_in = len_ff + 1'b1;
                     if (!blk_ff) begin
                        r_nt_in = notif_ff;
                     end else begin
                        def_in = 1'b1;
                     end
                     if (len_ff == '0) begin
                        node_we = 1'b1; node_wd.link = '0;
                        head_in = tid_ff; tail_in = tid_ff;
                     end else if (node_rd_ff.prio >= pri_ff) begin
                        // append behind the tail, then write the new node
                        node_we = 1'b1; node_wa = tail_ff;
                        node_wd.link = tid_ff; node_wd.prio = node_rd_ff.prio;
                        tail_in = tid_ff; new_link_in = '0;
                        st_in = S_WRNEW;
                     end else begin
                        // walk from head for the first lower-priority entry
                        node_ra = head_ff; cur_in = head_ff; hprev_in = 1'b0;
                        st_in = S_INS;
                     end
                  end
               end
               cptq_pkg::ACT_TAKE: begin
                  if (len_ff == '0) begin
                     r_st_in = cptq_pkg::ST_EMPTY;
                  end else begin
                     if (len_ff > LB'(1)) begin
                        head_in = node_rd_ff.link;
                     end
                     len_in = len_ff - 1'b1;
                     r_cnt_in = cnt_rd;
                     cnt_we = 1'b1; cnt_wa = head_ff; cnt_wd = '0;
                     run_in = head_ff; runv_in = 1'b1;
                     r_to_in = head_ff; r_tv_in = 1'b1;
                  end
               end
               cptq_pkg::ACT_FINISH: begin
                  runv_in = 1'b0;
               end
               cptq_pkg::ACT_CANCEL: begin
                  r_cnt_in = cnt_rd;
                  cnt_we = 1'b1; cnt_wd = '0;
                  if (runv_ff && run_ff == tid_ff) begin
                     r_st_in = cptq_pkg::ST_BUSY;
                  end
                  if (cnt_rd != '0) begin
                     if (head_ff == tid_ff) begin
                        if (len_ff > LB'(1)) begin
                           head_in = node_rd_ff.link;
                        end
                        len_in = len_ff - 1'b1;
                     end else begin
                        // walk from head for the predecessor
                        node_ra = head_ff; cur_in = head_ff;
                        st_in = S_CAN;
                     end
                  end
               end
               cptq_pkg::ACT_BLOCK: begin
                  blk_in = 1'b1;
               end
               cptq_pkg::ACT_UNBLOCK: begin
                  blk_in = 1'b0;
                  if (def_ff) begin
                     def_in = 1'b0;
                     r_nt_in = notif_ff;
                  end
               end
               cptq_pkg::ACT_SHUTDOWN: begin
                  on_in = 1'b0;
               end
               default: ;
            endcase
         end
         S_INS: begin
            // node_rd_ff holds the node of cur
            if (node_rd_ff.prio < pri_ff) begin
               new_link_in = cur_ff;
               node_we = 1'b1;
               if (hprev_ff) begin
                  node_wa = prev_ff; node_wd.link = tid_ff; node_wd.prio = prev_pri_ff;
                  st_in = S_WRNEW;
               end else begin
                  node_wd.link = cur_ff;
                  head_in = tid_ff;
                  st_in = S_DONE;
               end
            end else begin
               prev_in = cur_ff; prev_pri_in = node_rd_ff.prio; hprev_in = 1'b1;
               cur_in = node_rd_ff.link; node_ra = node_rd_ff.link;
            end
         end
         S_WRNEW: begin
            node_we = 1'b1;
            st_in = S_DONE;
         end
         S_CAN: begin
            // node_rd_ff holds the node of cur
            if (node_rd_ff.link == tid_ff) begin
               len_in = len_ff - 1'b1;
               if (tail_ff == tid_ff) begin
                  tail_in = cur_ff;
                  st_in = S_DONE;
               end else begin
                  // read the next link of the cancelled slot, then relink
                  prev_pri_in = node_rd_ff.prio; node_ra = tid_ff;
                  st_in = S_CAN2;
               end
            end else begin
               cur_in = node_rd_ff.link; node_ra = node_rd_ff.link;
            end
         end
         S_CAN2: begin
            node_we = 1'b1; node_wa = cur_ff;
            node_wd.link = node_rd_ff.link; node_wd.prio = prev_pri_ff;
            st_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               o_v_in = 1'b1;
               o_st_in = r_st_ff; o_to_in = r_to_ff; o_tv_in = r_tv_ff;
               o_nt_in = r_nt_ff; o_cnt_in = r_cnt_ff;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; act_ff <= cptq_pkg::ACT_ENQUEUE; tid_ff <= '0; pri_ff <= '0;
         head_ff <= '0; tail_ff <= '0; len_ff <= '0; run_ff <= '0; runv_ff <= 1'b0;
         blk_ff <= 1'b0; def_ff <= 1'b0; on_ff <= 1'b1; notif_ff <= 1'b1;
         cur_ff <= '0; prev_ff <= '0; prev_pri_ff <= '0; hprev_ff <= 1'b0;
         new_link_ff <= '0;
         r_st_ff <= cptq_pkg::ST_OK; r_to_ff <= '0; r_tv_ff <= 1'b0; r_nt_ff <= 1'b0;
         r_cnt_ff <= '0;
         o_v_ff <= 1'b0; o_st_ff <= cptq_pkg::ST_OK; o_to_ff <= '0; o_tv_ff <= 1'b0;
         o_nt_ff <= 1'b0; o_cnt_ff <= '0;
      end else begin
         st_ff <= st_in; act_ff <= act_in; tid_ff <= tid_in; pri_ff <= pri_in;
         head_ff <= head_in; tail_ff <= tail_in; len_ff <= len_in; run_ff <= run_in;
         runv_ff <= runv_in; blk_ff <= blk_in; def_ff <= def_in; on_ff <= on_in;
         notif_ff <= notif_in;
         cur_ff <= cur_in; prev_ff <= prev_in; prev_pri_ff <= prev_pri_in;
         hprev_ff <= hprev_in; new_link_ff <= new_link_in;
         r_st_ff <= r_st_in; r_to_ff <= r_to_in; r_tv_ff <= r_tv_in; r_nt_ff <= r_nt_in;
         r_cnt_ff <= r_cnt_in;
         o_v_ff <= o_v_in; o_st_ff <= o_st_in; o_to_ff <= o_to_in; o_tv_ff <= o_tv_in;
         o_nt_ff <= o_nt_in; o_cnt_ff <= o_cnt_in;
      end
   end

endmodule

[hw/rtl/cptq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptq_checker: port-level checks
// Watches the result channel of the task queue.
// ----------------------------------------------------------------------------
module cptq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_task_valid,
   input logic [1:0]                      rsp_status,
   input logic [cptq_pkg::COUNT_BITS-1:0] rsp_pending_count,
   input logic                            rsp_notify
);
   // a stalled result stays valid and keeps its pending count
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pending_count))
      else $error("stalled result changed");
   // a popped task always carries a nonzero count and OK status
   a_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_task_valid |->
         rsp_pending_count != '0 && rsp_status == cptq_pkg::ST_OK)
      else $error("popped task without count");
   // empty status never carries a task or a notify
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cptq_pkg::ST_EMPTY |-> !rsp_task_valid && !rsp_notify)
      else $error("empty status with task");
endmodule

bind coalescing_priority_task_queue cptq_checker u_cptq_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_task_valid(rsp_task_valid), .rsp_status(rsp_status),
   .rsp_pending_count(rsp_pending_count), .rsp_notify(rsp_notify)
);

[bench/coalescing_priority_task_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_priority_task_queue_tb: self-checking bench for the task queue
// Drives request sequences, register writes and random stalls into the queue
// and checks every response against a behavioral priority-list predictor.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [1:0]                      status;
   logic [cptq_pkg::SLOT_BITS-1:0]  task_out;
   logic                            task_valid;
   logic [cptq_pkg::COUNT_BITS-1:0] count;
   logic                            notify;
} queue_rsp_type;

// Behavioral copy of the task queue plus the responses still owed by the DUT.
class task_queue_tracker;
   int unsigned                        slot_count [cptq_pkg::NUM_TASKS];
   logic [cptq_pkg::PRIORITY_BITS-1:0] slot_prio  [cptq_pkg::NUM_TASKS];
   int                                 order[$];           // queued slots, head first
   int                                 run_slot;
   bit                                 run_valid, blocked, deferred, active, notifier;
   queue_rsp_type                      owed[$];
   int                                 mismatches;

   function new();
      foreach (slot_count[i]) slot_count[i] = 0;
      run_slot = 0;
      run_valid = 0;
      blocked = 0;
      deferred = 0;
      active = 1;
      notifier = 1;
      mismatches = 0;
   endfunction

   function void note_request(logic [2:0] act, logic [cptq_pkg::SLOT_BITS-1:0] id,
                              logic [cptq_pkg::PRIORITY_BITS-1:0] prio);
      queue_rsp_type r;
      int            pos;
      r = '0;
      case (act)
         cptq_pkg::ACT_ENQUEUE: begin
            if (!active) begin
               r.status = cptq_pkg::ST_INACTIVE;
            end else if (slot_count[id] != 0) begin
               // coalesce: bump the count, keep the original priority
               if (slot_count[id] < cptq_pkg::COUNT_MAX) slot_count[id]++;
            end else begin
               pos = order.size();
               foreach (order[i]) begin
                  if (slot_prio[order[i]] < prio) begin
                     pos = i;
                     break;
                  end
               end
               order.insert(pos, int'(id));
               slot_prio[id] = prio;
               slot_count[id] = 1;
               if (!blocked) r.notify = notifier;
               else deferred = 1;
            end
         end
         cptq_pkg::ACT_TAKE: begin
            if (order.size() == 0) begin
               r.status = cptq_pkg::ST_EMPTY;
            end else begin
               pos = order.pop_front();
               r.task_out = cptq_pkg::SLOT_BITS'(pos);
               r.task_valid = 1;
               r.count = cptq_pkg::COUNT_BITS'(slot_count[pos]);
               slot_count[pos] = 0;
               run_slot = pos;
               run_valid = 1;
            end
         end
         cptq_pkg::ACT_FINISH: run_valid = 0;
         cptq_pkg::ACT_CANCEL: begin
            foreach (order[i]) begin
               if (order[i] == id) begin
                  order.delete(i);
                  break;
               end
            end
            r.count = cptq_pkg::COUNT_BITS'(slot_count[id]);
            slot_count[id] = 0;
            if (run_valid && run_slot == id) r.status = cptq_pkg::ST_BUSY;
         end
         cptq_pkg::ACT_BLOCK: blocked = 1;
         cptq_pkg::ACT_UNBLOCK: begin
            blocked = 0;
            if (deferred) begin
               deferred = 0;
               r.notify = notifier;
            end
         end
         cptq_pkg::ACT_SHUTDOWN: active = 0;
         default: ;
      endcase
      owed.push_back(r);
   endfunction

   function void check_result(queue_rsp_type got);
      queue_rsp_type want;
      if (owed.size() == 0) begin
         $display("%t: response with nothing owed: %p", $realtime, got);
         mismatches++;
         return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
         $display("%t: status expected %0d actual %0d", $realtime, want.status, got.status);
         mismatches++;
      end
      if (got.task_out !== want.task_out) begin
         $display("%t: task_out expected %0d actual %0d", $realtime, want.task_out,
                  got.task_out);
         mismatches++;
      end
      if (got.task_valid !== want.task_valid) begin
         $display("%t: task_valid expected %0d actual %0d", $realtime, want.task_valid,
                  got.task_valid);
         mismatches++;
      end
      if (got.count !== want.count) begin
         $display("%t: pending_count expected %0d actual %0d", $realtime, want.count,
                  got.count);
         mismatches++;
      end
      if (got.notify !== want.notify) begin
         $display("%t: notify expected %0d actual %0d", $realtime, want.notify, got.notify);
         mismatches++;
      end
   endfunction
endclass

module coalescing_priority_task_queue_tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_WAIT = cptq_pkg::NUM_TASKS + 16;  // longest list walk plus margin
   localparam int SB          = cptq_pkg::SLOT_BITS;
   localparam int PB          = cptq_pkg::PRIORITY_BITS;
   localparam int CB          = cptq_pkg::COUNT_BITS;
   localparam logic [2:0] ACT_NONE = 3'd7;   // unused code, ignored by the block

   logic          clock, reset;
   logic          req_valid, req_ready;
   logic [2:0]    req_action;
   logic [SB-1:0] req_task_id;
   logic [PB-1:0] req_priority_req;
   logic          rsp_valid, rsp_ready;
   logic [1:0]    rsp_status;
   logic [SB-1:0] rsp_task_out;
   logic          rsp_task_valid;
   logic [CB-1:0] rsp_pending_count;
   logic          rsp_notify;
   logic          psel, penable, pwrite, pready;
   logic [2:0]    paddr;
   logic [31:0]   pwdata, prdata;

   task_queue_tracker tracker;
   bit                no_gaps;       // hold valid back-to-back in bursts
   int                stall_left;
   int unsigned       cycles;

   coalescing_priority_task_queue i_dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one request and hold it until the handshake; payload stays put.
   task automatic send_request(logic [2:0] act, logic [SB-1:0] id, logic [PB-1:0] prio);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_task_id      <= id;
      req_priority_req <= prio;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(act, id, prio);
   endtask

   // Drain: drop valid, wait for every owed response, then let the walk finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_notifier(bit value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(cptq_pkg::REG_HAS_NOTIFIER) << 2;
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.notifier = value;
   endtask

   // Random request mix; enqueue and take dominate so the list grows and shrinks.
   task automatic random_requests(int n);
      int            r;
      logic [2:0]    act;
      logic [SB-1:0] id;
      logic [PB-1:0] prio;
      repeat (n) begin
         r = $urandom_range(0, 99);
         id = ($urandom_range(0, 2) == 0) ? SB'($urandom_range(0, 7)) : SB'($urandom);
         prio = ($urandom_range(0, 1) == 0) ? PB'($urandom_range(0, 3) * 85) : PB'($urandom);
         if (r < 45) begin
            act = cptq_pkg::ACT_ENQUEUE;
         end else if (r < 70) begin
            act = cptq_pkg::ACT_TAKE;
         end else if (r < 82) begin
            act = cptq_pkg::ACT_CANCEL;
            // aim most cancels at queued or running slots
            if (tracker.order.size() != 0 && $urandom_range(0, 3) != 0)
               id = SB'(tracker.order[$urandom_range(0, tracker.order.size() - 1)]);
            else if ($urandom_range(0, 1) == 0)
               id = SB'(tracker.run_slot);
         end else if (r < 88) begin
            act = cptq_pkg::ACT_FINISH;
         end else if (r < 93) begin
            act = cptq_pkg::ACT_BLOCK;
         end else if (r < 98) begin
            act = cptq_pkg::ACT_UNBLOCK;
         end else begin
            act = ACT_NONE;
         end
         send_request(act, id, prio);
      end
   endtask

   // Response side: check on handshake, stall ready at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            tracker.check_result({rsp_status, rsp_task_out, rsp_task_valid,
                                  rsp_pending_count, rsp_notify});
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if the queue stops answering.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      tracker          = new();
      no_gaps          = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = cptq_pkg::ACT_ENQUEUE;
      req_task_id      = '0;
      req_priority_req = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ties, coalescing, running replacement, busy cancel, deferred wake.
      write_notifier(1'b1);
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd63, 8'd255);
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd0,  8'd0);
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd5,  8'd0);
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd42, 8'd170);
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd21, 8'd85);
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd63, 8'd1);    // already queued: count only
      send_request(cptq_pkg::ACT_TAKE,    6'd0,  8'd0);
      send_request(cptq_pkg::ACT_TAKE,    6'd0,  8'd0);    // new head replaces running
      send_request(cptq_pkg::ACT_CANCEL,  6'd5,  8'd0);    // unlink at the tail
      send_request(cptq_pkg::ACT_CANCEL,  6'd5,  8'd0);    // not queued any more
      send_request(cptq_pkg::ACT_CANCEL,  6'd42, 8'd0);    // running slot
      send_request(cptq_pkg::ACT_FINISH,  6'd0,  8'd0);
      send_request(cptq_pkg::ACT_FINISH,  6'd0,  8'd0);    // nothing running
      send_request(cptq_pkg::ACT_TAKE,    6'd0,  8'd0);
      send_request(cptq_pkg::ACT_TAKE,    6'd0,  8'd0);
      send_request(cptq_pkg::ACT_TAKE,    6'd0,  8'd0);    // empty queue
      send_request(cptq_pkg::ACT_BLOCK,   6'd0,  8'd0);
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd10, 8'd128);  // deferred wake
      send_request(cptq_pkg::ACT_ENQUEUE, 6'd11, 8'd128);
      send_request(cptq_pkg::ACT_UNBLOCK, 6'd0,  8'd0);    // releases the wake
      send_request(cptq_pkg::ACT_UNBLOCK, 6'd0,  8'd0);    // no wake pending
      send_request(ACT_NONE,              6'd63, 8'd255);
      settle();

      random_requests(700);
      settle();
      write_notifier(1'b0);
      random_requests(700);
      settle();
      write_notifier(1'b1);

      random_requests(60);
      while (tracker.order.size() != 0) send_request(cptq_pkg::ACT_TAKE, 6'd0, 8'd0);
      settle();

      // Shutdown last: enqueues are refused, everything else keeps working.
      send_request(cptq_pkg::ACT_ENQUEUE,  6'd3, 8'd200);
      send_request(cptq_pkg::ACT_SHUTDOWN, 6'd0, 8'd0);
      send_request(cptq_pkg::ACT_ENQUEUE,  6'd4, 8'd9);
      random_requests(40);
      settle();

      if (tracker.mismatches == 0 && tracker.owed.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[coalescing_priority_task_queue.f]
hw/rtl/cptq_pkg.sv
hw/rtl/coalescing_priority_task_queue.sv
hw/rtl/cptq_checker.sv
bench/coalescing_priority_task_queue_tb.sv
